>>> sv/back_easing_interpolator_macros.svh
// Assertion macros for the back easing interpolator.
// Expects clk and arst_n in the scope of each use.
`ifndef BACK_EASING_INTERPOLATOR_MACROS_SVH
`define BACK_EASING_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define BEI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bei assertion failed");

// next-cycle implication
`define BEI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bei assertion failed");

`endif

>>> sv/bei_pkg.sv
// Shared types, constants and helpers of the back easing interpolator.
// No dependencies.
package bei_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam logic [15:0] DURATION_RST = 16'd1024;

	// operation codes; bit 1 selects in-out, so the spare code eases in-out too
	localparam logic [1:0] OP_EASE_IN     = 2'd0;
	localparam logic [1:0] OP_EASE_OUT    = 2'd1;
	localparam logic [1:0] OP_EASE_IN_OUT = 2'd2;
	localparam logic [1:0] OP_EASE_SPARE  = 2'd3;

	// overshoot constants in Q2.24
	localparam logic [27:0] S_A_Q24 = 28'd28547775;
	localparam logic [27:0] S_IO_Q24 = 28'd43535357;

	localparam int OUT_MAX = 131071;
	localparam int OUT_MIN = -131072;

	// per-item fields that ride along with the arithmetic
	typedef struct packed {
		logic [1:0] op;
		logic signed [15:0] b;
		logic signed [16:0] c;
		logic zero;
	} bei_side_t;

	// round a Q2.24 constant half-up to frac fraction bits
	function automatic logic [27:0] q24_to_frac(input int frac, input logic [27:0] c);
		int sh;
		sh = 24 - frac;
		if (sh == 0)
			return c;
		return (c + (28'd1 << (sh - 1))) >> sh;
	endfunction

endpackage

>>> sv/bei_div.sv
// Pipelined restoring divider: u = min(t, d) * 2^F / d, one quotient bit per stage.
// Depends on bei_pkg.
module bei_div #(
	parameter int FRAC_BITS = bei_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [15:0]           duration,
	input  logic                  in_valid,
	input  logic [15:0]           elapsed_time,
	input  bei_pkg::bei_side_t    side_in,
	output logic                  out_valid,
	output logic [FRAC_BITS:0]    quotient,
	output bei_pkg::bei_side_t    side_out
);

	localparam int NS = FRAC_BITS + 1;

	logic               vld_s  [NS];
	logic [16:0]        rem_s  [NS];
	logic [FRAC_BITS:0] quo_s  [NS];
	bei_pkg::bei_side_t side_s [NS];

	logic [16:0] dur_x;
	assign dur_x = {1'b0, duration};

	for (genvar i = 0; i < NS; i++) begin : g_stage
		logic [16:0]        rem_in;
		logic [FRAC_BITS:0] quo_in;
		logic               vld_in;
		bei_pkg::bei_side_t side_w;
		logic               ge;
		logic [16:0]        rem_sub;

		if (i == 0) begin : g_first
			// clamp time to the duration so the quotient stays within one
			assign rem_in = (elapsed_time > duration) ? dur_x : {1'b0, elapsed_time};
			assign quo_in = '0;
			assign vld_in = in_valid;
			assign side_w = side_in;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign quo_in = quo_s[i-1];
			assign vld_in = vld_s[i-1];
			assign side_w = side_s[i-1];
		end

		assign ge      = rem_in >= dur_x;
		assign rem_sub = ge ? (rem_in - dur_x) : rem_in;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i] <= 1'b0;
			else if (en)
				vld_s[i] <= vld_in;
		end

		// remainder is below the divisor after the subtract, so 16 bits hold it
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= {rem_sub[15:0], 1'b0};
				quo_s[i]  <= {quo_in[FRAC_BITS-1:0], ge};
				side_s[i] <= side_w;
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign quotient  = quo_s[NS-1];
	assign side_out  = side_s[NS-1];

endmodule

>>> sv/bei_poly.sv
// Back cubic evaluation, scaling by change, rounding and saturation in six stages.
// Depends on bei_pkg.
module bei_poly #(
	parameter int FRAC_BITS = bei_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [FRAC_BITS:0]    u,
	input  bei_pkg::bei_side_t    side_in,
	output logic                  out_valid,
	output logic signed [17:0]    out_value
);

	localparam int F = FRAC_BITS;

	localparam logic [1:0] ADD_ZERO = 2'd0;
	localparam logic [1:0] ADD_ONE  = 2'd1;
	localparam logic [1:0] ADD_TWO  = 2'd2;

	localparam logic [27:0]  S_A_W  = bei_pkg::q24_to_frac(F, bei_pkg::S_A_Q24);
	localparam logic [27:0]  S_IO_W = bei_pkg::q24_to_frac(F, bei_pkg::S_IO_Q24);
	localparam logic [F+1:0] S_A    = S_A_W[F+1:0];
	localparam logic [F+1:0] S_IO   = S_IO_W[F+1:0];

	localparam logic signed [22:0] Y_MAX = 23'(bei_pkg::OUT_MAX);
	localparam logic signed [22:0] Y_MIN = 23'(bei_pkg::OUT_MIN);

	logic [6:1] vld_s;

	// ---------------- stage 1: curve argument and constants
	logic [F+1:0] v2;
	logic [F+2:0] v2m;
	logic signed [F+1:0] x_w;
	logic [F+1:0] s_w;
	logic outm_w, half_w;
	logic [1:0] add_w;

	assign v2  = {u, 1'b0};
	assign v2m = {1'b0, v2} - {3'b010, {F{1'b0}}};

	always_comb begin
		x_w    = $signed({1'b0, u});
		s_w    = S_A;
		outm_w = 1'b0;
		half_w = 1'b0;
		add_w  = ADD_ZERO;
		case (side_in.op)
			bei_pkg::OP_EASE_IN: begin
				x_w = $signed({1'b0, u});
			end
			bei_pkg::OP_EASE_OUT: begin
				x_w    = $signed({1'b0, u} - {2'b01, {F{1'b0}}});
				outm_w = 1'b1;
				add_w  = ADD_ONE;
			end
			default: begin
				// in-out: both remaining codes
				s_w    = S_IO;
				half_w = 1'b1;
				if (v2[F+1:F] == 2'b00) begin
					x_w = $signed(v2);
				end else begin
					x_w    = $signed(v2m[F+1:0]);
					outm_w = 1'b1;
					add_w  = ADD_TWO;
				end
			end
		endcase
	end

	logic signed [F+1:0] x_s1;
	logic [F+1:0]        s_s1;
	logic                outm_s1, half_s1;
	logic [1:0]          add_s1;
	bei_pkg::bei_side_t  side_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_w;
			s_s1    <= s_w;
			outm_s1 <= outm_w;
			half_s1 <= half_w;
			add_s1  <= add_w;
			side_s1 <= side_in;
		end
	end

	// ---------------- stage 2: x^2 and (s+1)x
	logic signed [2*F+3:0] xx_p, xx_r;
	logic [F+2:0]          sp1;
	logic signed [2*F+5:0] q_p, q_r;

	assign sp1  = {1'b0, s_s1} + {3'b001, {F{1'b0}}};
	assign xx_p = x_s1 * x_s1;
	assign xx_r = (xx_p + $signed({{(F+4){1'b0}}, 1'b1, {(F-1){1'b0}}})) >>> F;
	assign q_p  = $signed({1'b0, sp1}) * x_s1;
	assign q_r  = (q_p + $signed({{(F+6){1'b0}}, 1'b1, {(F-1){1'b0}}})) >>> F;

	logic [F:0]          x2_s2;
	logic signed [F+2:0] q_s2;
	logic [F+1:0]        s_s2;
	logic                outm_s2, half_s2;
	logic [1:0]          add_s2;
	bei_pkg::bei_side_t  side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s2   <= xx_r[F:0];
			q_s2    <= q_r[F+2:0];
			s_s2    <= s_s1;
			outm_s2 <= outm_s1;
			half_s2 <= half_s1;
			add_s2  <= add_s1;
			side_s2 <= side_s1;
		end
	end

	// ---------------- stage 3: (s+1)x -/+ s
	logic signed [F+3:0] q_x, s_x;

	assign q_x = {q_s2[F+2], q_s2};
	assign s_x = $signed({2'b00, s_s2});

	logic [F:0]          x2_s3;
	logic signed [F+3:0] p_s3;
	logic                half_s3;
	logic [1:0]          add_s3;
	bei_pkg::bei_side_t  side_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s3   <= x2_s2;
			p_s3    <= outm_s2 ? (q_x + s_x) : (q_x - s_x);
			half_s3 <= half_s2;
			add_s3  <= add_s2;
			side_s3 <= side_s2;
		end
	end

	// ---------------- stage 4: f = x^2 * p, plus the curve offset
	logic signed [2*F+5:0] f_p, f_r;
	logic signed [F+4:0]   addend;

	assign f_p    = $signed({1'b0, x2_s3}) * p_s3;
	assign f_r    = (f_p + $signed({{(F+6){1'b0}}, 1'b1, {(F-1){1'b0}}})) >>> F;
	assign addend = $signed({3'b000, add_s3, {F{1'b0}}});

	logic signed [F+4:0] f_s4;
	logic                half_s4;
	bei_pkg::bei_side_t  side_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			f_s4    <= f_r[F+4:0] + addend;
			half_s4 <= half_s3;
			side_s4 <= side_s3;
		end
	end

	// ---------------- stage 5: c * f
	logic signed [F+21:0] m_s5;
	logic                 half_s5;
	bei_pkg::bei_side_t   side_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			m_s5    <= side_s4.c * f_s4;
			half_s5 <= half_s4;
			side_s5 <= side_s4;
		end
	end

	// ---------------- stage 6: round, add start, saturate
	logic signed [F+21:0] m_rf, m_rh, m_r;
	logic signed [22:0]   y_w, y_sum;
	logic signed [17:0]   y_sat;

	assign m_rf = (m_s5 + $signed({{22{1'b0}}, 1'b1, {(F-1){1'b0}}})) >>> F;
	assign m_rh = (m_s5 + $signed({{21{1'b0}}, 1'b1, {F{1'b0}}})) >>> (F + 1);
	assign m_r  = half_s5 ? m_rh : m_rf;

	always_comb begin
		// zero duration jumps straight to the target
		if (side_s5.zero)
			y_sum = 23'(side_s5.b) + 23'(side_s5.c);
		else
			y_sum = 23'(side_s5.b) + $signed(m_r[21:0]);
		y_w = y_sum;
		if (y_sum > Y_MAX)
			y_w = Y_MAX;
		else if (y_sum < Y_MIN)
			y_w = Y_MIN;
		y_sat = y_w[17:0];
	end

	logic signed [17:0] y_s6;

	always_ff @(posedge clk) begin
		if (en)
			y_s6 <= y_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[5:1], in_valid};
		end
	end

	assign out_valid = vld_s[6];
	assign out_value = y_s6;

endmodule

>>> sv/bei_outbuf.sv
// Output register with one skid entry; stalls the pipeline only when the skid is full.
// No dependencies.
module bei_outbuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [17:0] in_value,
	output logic               en,
	output logic               full,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [17:0] eased_value
);

	logic               out_valid_q, skid_valid_q;
	logic signed [17:0] out_data_q, skid_data_q;
	logic               hold;

	assign hold = out_valid_q && !out_ready;
	assign en   = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!skid_valid_q) begin
			if (hold)
				skid_valid_q <= in_valid;
			else
				out_valid_q <= in_valid;
		end else if (out_ready) begin
			// drain the skid into the output register
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q) begin
			if (hold)
				skid_data_q <= in_value;
			else
				out_data_q <= in_value;
		end else if (out_ready) begin
			out_data_q <= skid_data_q;
		end
	end

	assign full        = skid_valid_q;
	assign out_valid   = out_valid_q;
	assign eased_value = out_data_q;

endmodule

>>> sv/back_easing_interpolator.sv
// Back easing interpolator top level: duration register, divider, cubic, output buffer.
// Depends on bei_pkg, bei_div, bei_poly, bei_outbuf and the assertion macro header.
//
// Usage:
//   Write duration (ticks) through cfg_we/cfg_wdata while nothing is in flight.
//   Input channel in_valid/in_ready carries operation, elapsed_time, start_value
//   and change; output channel out_valid/out_ready carries eased_value.
//   Throughput: one transfer per cycle on each side, sustained while out_ready stays high.
//   An input passes FRAC_BITS + 1 divider stages, one quotient bit each, six
//   cubic/scale stages, and the output register on its way to out_valid.
//   Reset clears all valid bits and sets duration to 1024; no results are
//   pending afterwards.
//   When the receiver stalls, the output holds and one more result lands in
//   a skid entry; in_ready then drops and the whole pipeline freezes in
//   place until out_ready returns. in_ready comes from a register only.
`include "back_easing_interpolator_macros.svh"

module back_easing_interpolator #(
	parameter int FRAC_BITS = bei_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [15:0]        elapsed_time,
	input  logic signed [15:0] start_value,
	input  logic signed [16:0] change,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [17:0] eased_value
);

	logic [15:0] duration_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			duration_q <= bei_pkg::DURATION_RST;
		else if (cfg_we)
			duration_q <= cfg_wdata;
	end

	logic               en, buf_full;
	bei_pkg::bei_side_t side_in, div_side;
	logic               div_valid;
	logic [FRAC_BITS:0] div_quo;
	logic               poly_valid;
	logic signed [17:0] poly_value;

	assign in_ready = en;

	always_comb begin
		side_in.op   = operation;
		side_in.b    = start_value;
		side_in.c    = change;
		side_in.zero = (duration_q == 16'd0);
	end

	bei_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.duration     (duration_q),
		.in_valid     (in_valid),
		.elapsed_time (elapsed_time),
		.side_in      (side_in),
		.out_valid    (div_valid),
		.quotient     (div_quo),
		.side_out     (div_side)
	);

	bei_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.u         (div_quo),
		.side_in   (div_side),
		.out_valid (poly_valid),
		.out_value (poly_value)
	);

	bei_outbuf u_outbuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (poly_valid),
		.in_value    (poly_value),
		.en          (en),
		.full        (buf_full),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.eased_value (eased_value)
	);

	// a filled skid entry always sits behind a valid output
	`BEI_ASSERT_IMP(a_skid_behind_out, buf_full, out_valid)
	// the pipeline only freezes after a stalled output
	`BEI_ASSERT_IMP(a_stall_cause, !in_ready, $past(out_valid && !out_ready))
	// a transfer out of a full buffer drains the skid and keeps the output valid
	`BEI_ASSERT_NXT(a_skid_drain, buf_full && out_ready, out_valid && !buf_full)

endmodule
